[src/ppf_pkg.sv]
// ----------------------------------------------------------------------------
// ppf_pkg: shared definitions for the projection profile peak finder
// Constants, register indexes, result kinds, controller states and the
// command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package ppf_pkg;

  // Default sizes of the column memory and the row range.
  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  // Configuration register widths and reset values.
  localparam int CFG_W   = 11;
  localparam int THR_W   = 8;
  localparam int IDX_W   = 2;
  localparam logic [THR_W-1:0] THR_RESET = 8'd125;
  localparam logic [CFG_W-1:0] LIM_RESET = 11'd1024;

  // Width of the clamped limits; holds any limit up to 4096.
  localparam int LIM_W   = 13;
  localparam int LIM_MIN = 2;

  // Result field widths.
  localparam int POS_W  = 10;
  localparam int KIND_W = 2;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_COLS      = 2'd1,
    REG_ROWS      = 2'd2
  } reg_idx_t;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_ROW  = 2'd0,
    KIND_COL  = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic exec;
  } ctrl_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic clr_done;
  } ctrl_sts_t;

  // Saturate a size register into the range [2, maxv].
  function automatic logic [LIM_W-1:0] clamp_limit(input logic [CFG_W-1:0] v,
                                                   input int maxv);
    logic [LIM_W-1:0] ext;
    logic [LIM_W-1:0] maxl;
    ext  = LIM_W'(v);
    maxl = LIM_W'(maxv);
    if (ext < LIM_W'(LIM_MIN)) begin
      return LIM_W'(LIM_MIN);
    end else if (ext > maxl) begin
      return maxl;
    end
    return ext;
  endfunction

endpackage

[src/ppf_tracker.sv]
// ----------------------------------------------------------------------------
// ppf_tracker: local maximum tracker over a sequence of counts
// Takes one pair of neighboring counts per step and flags a peak when a rise
// is followed by a fall; on a plateau it gives the floor of the midpoint.
// ----------------------------------------------------------------------------
module ppf_tracker #(
  parameter int CW = 11,
  parameter int IW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          init,
  input  logic          step,
  input  logic [CW-1:0] a,
  input  logic [CW-1:0] b,
  input  logic [IW-1:0] idx,
  output logic          peak,
  output logic [IW-1:0] pos
);

  logic          rising;
  logic          plateau;
  logic [IW-1:0] plateau_start;
  logic [IW:0]   mid_sum;

  // Peak decision and reported position for the current pair.
  always_comb begin
    mid_sum = {1'b0, plateau_start} + {1'b0, idx};
    peak    = step && (a > b) && rising;
    pos     = plateau ? mid_sum[IW:1] : idx;
  end

  // Tracker state update.
  always_ff @(posedge clk) begin
    if (rst || init) begin
      rising        <= 1'b0;
      plateau       <= 1'b0;
      plateau_start <= '0;
    end else if (step) begin
      if ((a > b) && rising) begin
        rising  <= 1'b0;
        plateau <= 1'b0;
      end else if (a < b) begin
        rising  <= 1'b1;
        plateau <= 1'b0;
      end else if ((a == b) && !plateau) begin
        plateau       <= 1'b1;
        plateau_start <= idx;
      end
    end
  end

endmodule

[src/ppf_ctrl.sv]
// ----------------------------------------------------------------------------
// ppf_ctrl: controller for the projection profile peak finder
// Runs the clearing pass after reset, then takes one word at a time and
// steps the datapath through an execute state for it.
// ----------------------------------------------------------------------------
module ppf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ppf_pkg::ctrl_sts_t sts,
  output logic              busy,
  output ppf_pkg::ctrl_cmd_t cmd
);

  ppf_pkg::state_t state;
  ppf_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppf_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ppf_pkg::ST_CLEAR: begin
        if (sts.clr_done) state_next = ppf_pkg::ST_IDLE;
      end
      ppf_pkg::ST_IDLE: begin
        if (start) state_next = ppf_pkg::ST_EXEC;
      end
      ppf_pkg::ST_EXEC: begin
        state_next = ppf_pkg::ST_IDLE;
      end
      default: begin
        state_next = ppf_pkg::ST_CLEAR;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    busy         = 1'b1;
    cmd.clr_step = 1'b0;
    cmd.accept   = 1'b0;
    cmd.exec     = 1'b0;
    case (state)
      ppf_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      ppf_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      ppf_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[src/ppf_datapath.sv]
// ----------------------------------------------------------------------------
// ppf_datapath: counters, column count memory and peak trackers
// Holds the configuration, the row and column counts, the row and column
// peak trackers and the registered result word.
// ----------------------------------------------------------------------------
module ppf_datapath #(
  parameter int MAX_COLS = ppf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = ppf_pkg::MAX_ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ppf_pkg::ctrl_cmd_t          cmd,
  output ppf_pkg::ctrl_sts_t          sts,
  input  logic                        func,
  input  logic [7:0]                  pixel,
  input  logic                        wr_en,
  input  logic [ppf_pkg::IDX_W-1:0]   wr_index,
  input  logic [ppf_pkg::CFG_W-1:0]   wr_data,
  output logic                        done,
  output logic [ppf_pkg::KIND_W-1:0]  kind,
  output logic [ppf_pkg::POS_W-1:0]   position,
  output logic                        last
);

  localparam int CPOS_W = $clog2(MAX_COLS);
  localparam int RPOS_W = $clog2(MAX_ROWS + 1);
  localparam int RCNT_W = $clog2(MAX_COLS + 1);
  localparam int CCNT_W = $clog2(MAX_ROWS + 1);
  localparam int LIM_W  = ppf_pkg::LIM_W;
  localparam int POS_W  = ppf_pkg::POS_W;

  // Configuration registers.
  logic [ppf_pkg::THR_W-1:0] thr;
  logic [ppf_pkg::CFG_W-1:0] cols_cfg;
  logic [ppf_pkg::CFG_W-1:0] rows_cfg;

  // Column count memory and its clearing pointer.
  logic [CCNT_W-1:0] ccnt_mem [MAX_COLS];
  logic [CCNT_W-1:0] rd_q;
  logic [CPOS_W-1:0] clr_addr;

  // Captured input word.
  logic       func_q;
  logic [7:0] pixel_q;

  // Image state.
  logic [RCNT_W-1:0] row_acc;
  logic [RCNT_W-1:0] prev_row;
  logic [CPOS_W-1:0] col_pos;
  logic [RPOS_W-1:0] row_pos;
  logic [CPOS_W-1:0] scan_pos;
  logic [CCNT_W-1:0] prev_col;

  // Result registers.
  ppf_pkg::kind_t    kind_q;
  logic [POS_W-1:0]  pos_q;

  // Execute-cycle decode.
  logic [LIM_W-1:0]  cols_lim;
  logic [LIM_W-1:0]  rows_lim;
  logic              pix_live;
  logic              dark;
  logic [RCNT_W-1:0] row_acc_new;
  logic              row_end;
  logic              row_step;
  logic              scan_exec;
  logic              scan_last;
  logic              col_step;
  logic              row_peak;
  logic              col_peak;
  logic [RPOS_W-1:0] row_idx;
  logic [CPOS_W-1:0] col_idx;
  logic [RPOS_W-1:0] row_pk_pos;
  logic [CPOS_W-1:0] col_pk_pos;
  logic [RPOS_W+POS_W-1:0] row_pos_ext;
  logic [CPOS_W+POS_W-1:0] col_pos_ext;

  assign sts.clr_done = (clr_addr == CPOS_W'(MAX_COLS - 1));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr      <= ppf_pkg::THR_RESET;
      cols_cfg <= ppf_pkg::LIM_RESET;
      rows_cfg <= ppf_pkg::LIM_RESET;
    end else if (wr_en) begin
      case (wr_index)
        ppf_pkg::REG_THRESHOLD: thr      <= wr_data[ppf_pkg::THR_W-1:0];
        ppf_pkg::REG_COLS:      cols_cfg <= wr_data;
        ppf_pkg::REG_ROWS:      rows_cfg <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // Decode of the word in the execute cycle.
  always_comb begin
    cols_lim    = ppf_pkg::clamp_limit(cols_cfg, MAX_COLS);
    rows_lim    = ppf_pkg::clamp_limit(rows_cfg, MAX_ROWS);
    pix_live    = cmd.exec && !func_q && (LIM_W'(row_pos) < rows_lim);
    dark        = pixel_q < thr;
    row_acc_new = row_acc + RCNT_W'(dark);
    row_end     = (LIM_W'(col_pos) + LIM_W'(1)) >= cols_lim;
    row_step    = pix_live && row_end && (row_pos != '0);
    row_idx     = row_pos - RPOS_W'(1);
    scan_exec   = cmd.exec && func_q;
    scan_last   = (LIM_W'(scan_pos) + LIM_W'(1)) >= cols_lim;
    col_step    = scan_exec && (scan_pos != '0);
    col_idx     = scan_pos - CPOS_W'(1);
    row_pos_ext = {{POS_W{1'b0}}, row_pk_pos};
    col_pos_ext = {{POS_W{1'b0}}, col_pk_pos};
  end

  // Row peak tracker.
  ppf_tracker #(
    .CW (RCNT_W),
    .IW (RPOS_W)
  ) u_row_trk (
    .clk  (clk),
    .rst  (rst),
    .init (scan_exec && scan_last),
    .step (row_step),
    .a    (prev_row),
    .b    (row_acc_new),
    .idx  (row_idx),
    .peak (row_peak),
    .pos  (row_pk_pos)
  );

  // Column peak tracker.
  ppf_tracker #(
    .CW (CCNT_W),
    .IW (CPOS_W)
  ) u_col_trk (
    .clk  (clk),
    .rst  (rst),
    .init (scan_exec && scan_last),
    .step (col_step),
    .a    (prev_col),
    .b    (rd_q),
    .idx  (col_idx),
    .peak (col_peak),
    .pos  (col_pk_pos)
  );

  // Column count memory: read at accept, written in execute or clearing.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_q <= ccnt_mem[func ? scan_pos : col_pos];
    end
    if (cmd.clr_step) begin
      ccnt_mem[clr_addr] <= '0;
    end else if (scan_exec) begin
      ccnt_mem[scan_pos] <= '0;
    end else if (pix_live && dark) begin
      ccnt_mem[col_pos] <= rd_q + CCNT_W'(1);
    end
  end

  // Clearing pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step && !sts.clr_done) begin
      clr_addr <= clr_addr + CPOS_W'(1);
    end
  end

  // Captured input word.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q  <= func;
      pixel_q <= pixel;
    end
  end

  // Row and scan counters.
  always_ff @(posedge clk) begin
    if (rst || (scan_exec && scan_last)) begin
      row_acc  <= '0;
      prev_row <= '0;
      col_pos  <= '0;
      row_pos  <= '0;
      scan_pos <= '0;
      prev_col <= '0;
    end else begin
      if (pix_live) begin
        if (row_end) begin
          prev_row <= row_acc_new;
          row_acc  <= '0;
          col_pos  <= '0;
          row_pos  <= row_pos + RPOS_W'(1);
        end else begin
          row_acc <= row_acc_new;
          col_pos <= col_pos + CPOS_W'(1);
        end
      end
      if (scan_exec) begin
        prev_col <= rd_q;
        scan_pos <= scan_pos + CPOS_W'(1);
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= scan_exec || row_peak;
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (func_q) begin
        kind_q <= col_peak ? ppf_pkg::KIND_COL : ppf_pkg::KIND_NONE;
        pos_q  <= col_peak ? col_pos_ext[POS_W-1:0] : '0;
        last   <= scan_last;
      end else begin
        kind_q <= ppf_pkg::KIND_ROW;
        pos_q  <= row_pos_ext[POS_W-1:0];
        last   <= 1'b0;
      end
    end
  end

  assign kind     = kind_q;
  assign position = pos_q;

`ifndef SYNTHESIS
  // A result word only follows an execute cycle.
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.exec))
    else $error("result strobe without a preceding execute cycle");

  // A scan step without a peak carries position zero.
  a_none_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (kind_q == ppf_pkg::KIND_NONE)) |-> (pos_q == '0))
    else $error("scan step without peak has a nonzero position");

  // The final scan flag never rides on a row peak.
  a_last_not_row: assert property (@(posedge clk) disable iff (rst)
    (done && last) |-> (kind_q != ppf_pkg::KIND_ROW))
    else $error("last flag on a row peak");

  // The final scan step restarts the image.
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (done && last) |-> ((scan_pos == '0) && (row_pos == '0) && (col_pos == '0)))
    else $error("image state not restarted after the final scan step");
`endif

endmodule

[src/projection_profile_peak_finder.sv]
// ----------------------------------------------------------------------------
// projection_profile_peak_finder: row and column projection peak finder
// Counts dark pixels per row and per column and reports local maxima of the
// row profile while pixels arrive and of the column profile during a scan.
// ----------------------------------------------------------------------------
// Usage:
//   Input words are taken on a rising edge with start high and busy low.
//   func 0 carries a pixel in raster order; func 1 is one column scan step.
//   For each word the accept edge reads the column count memory, and the
//   execute cycle after it updates counts and trackers. busy is high during
//   that execute cycle, so no new word is taken until it is over. A result
//   word appears on kind, position and last with done high for one cycle,
//   starting the cycle after the execute cycle. A pixel word gives a result
//   only on a row peak; a scan step always gives one.
//   The receiver cannot stall: each result is on the ports for one cycle.
//   Configuration is written through wr_en, wr_index and wr_data at any edge
//   and takes effect at once; it is meant to change only while idle.
//   After reset the column count memory is cleared, one entry per cycle;
//   busy stays high during that pass.
// ----------------------------------------------------------------------------
module projection_profile_peak_finder #(
  parameter int MAX_COLS = ppf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = ppf_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       func,
  input  logic [7:0]                 pixel,
  input  logic                       wr_en,
  input  logic [ppf_pkg::IDX_W-1:0]  wr_index,
  input  logic [ppf_pkg::CFG_W-1:0]  wr_data,
  output logic                       done,
  output logic [ppf_pkg::KIND_W-1:0] kind,
  output logic [ppf_pkg::POS_W-1:0]  position,
  output logic                       last
);

  ppf_pkg::ctrl_cmd_t cmd;
  ppf_pkg::ctrl_sts_t sts;

  // Sequencing of the clearing pass and the word execution.
  ppf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Counters, memory, trackers and result register.
  ppf_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .func     (func),
    .pixel    (pixel),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .done     (done),
    .kind     (kind),
    .position (position),
    .last     (last)
  );

endmodule

[test/ppf_peak_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppf_peak_checker: result checker for the projection profile peak finder
// Watches the command, register and result ports of the block, keeps its own
// row and column dark profiles and peak trackers, and compares every result
// word, field by field and in order, against the word it expects.
// ----------------------------------------------------------------------------
module ppf_peak_checker #(
  parameter int MAX_COLS = ppf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = ppf_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       func,
  input  logic [7:0]                 pixel,
  input  logic                       wr_en,
  input  logic [ppf_pkg::IDX_W-1:0]  wr_index,
  input  logic [ppf_pkg::CFG_W-1:0]  wr_data,
  input  logic                       done,
  input  logic [ppf_pkg::KIND_W-1:0] kind,
  input  logic [ppf_pkg::POS_W-1:0]  position,
  input  logic                       last,
  output int                         outstanding,
  output int                         errors,
  output int                         words_in,
  output int                         scan_words,
  output int                         row_peaks,
  output int                         col_peaks
);

  // Local maximum tracker over a sequence of counts.
  typedef struct packed {
    logic                      rising;
    logic                      plateau;
    logic [ppf_pkg::POS_W-1:0] plateau_first;
  } peak_trk_t;

  // One expected result word.
  typedef struct packed {
    ppf_pkg::kind_t            kind;
    logic [ppf_pkg::POS_W-1:0] position;
    logic                      last;
  } peak_word_t;

  logic [ppf_pkg::CFG_W-1:0] column_dark [MAX_COLS];
  logic [ppf_pkg::CFG_W-1:0] row_dark;
  logic [ppf_pkg::CFG_W-1:0] prev_row_dark;
  logic [ppf_pkg::CFG_W-1:0] prev_col_dark;
  int                        col_idx;
  int                        row_idx;
  int                        scan_idx;
  peak_trk_t                 row_trk;
  peak_trk_t                 col_trk;
  logic [ppf_pkg::THR_W-1:0] threshold;
  logic [ppf_pkg::CFG_W-1:0] cols_reg;
  logic [ppf_pkg::CFG_W-1:0] rows_reg;
  peak_word_t                expected_peaks [$];
  int                        reported;

  function automatic int size_in_use(input logic [ppf_pkg::CFG_W-1:0] v, input int maxv);
    if (v < 2) begin
      return 2;
    end else if (int'(v) > maxv) begin
      return maxv;
    end
    return int'(v);
  endfunction

  // One tracker step on the count pair at index i and i + 1.
  function automatic void advance_peak_tracker(input peak_trk_t t,
                                               input logic [ppf_pkg::CFG_W-1:0] a,
                                               input logic [ppf_pkg::CFG_W-1:0] b,
                                               input int i,
                                               output peak_trk_t nt,
                                               output logic hit,
                                               output logic [ppf_pkg::POS_W-1:0] pos);
    int mid;
    nt  = t;
    hit = 1'b0;
    pos = '0;
    if (a > b && t.rising) begin
      mid        = t.plateau ? (int'(t.plateau_first) + i) / 2 : i;
      pos        = ppf_pkg::POS_W'(mid);
      hit        = 1'b1;
      nt.rising  = 1'b0;
      nt.plateau = 1'b0;
    end else if (a < b) begin
      nt.rising  = 1'b1;
      nt.plateau = 1'b0;
    end else if (a == b && !t.plateau) begin
      nt.plateau       = 1'b1;
      nt.plateau_first = ppf_pkg::POS_W'(i);
    end
  endfunction

  // All image state but the column memory returns to zero for a new image.
  task automatic restart_image;
    row_dark      = '0;
    prev_row_dark = '0;
    prev_col_dark = '0;
    col_idx       = 0;
    row_idx       = 0;
    scan_idx      = 0;
    row_trk       = '0;
    col_trk       = '0;
  endtask

  // Work out the result, if any, of one accepted input word.
  task automatic predict_word(input logic f, input logic [7:0] p);
    int                        cols_eff;
    int                        rows_eff;
    logic                      hit;
    logic                      is_last;
    logic [ppf_pkg::POS_W-1:0] pos;
    logic [ppf_pkg::CFG_W-1:0] cur;
    peak_trk_t                 nt;
    peak_word_t                w;
    cols_eff = size_in_use(cols_reg, MAX_COLS);
    rows_eff = size_in_use(rows_reg, MAX_ROWS);
    hit      = 1'b0;
    pos      = '0;
    words_in++;
    if (!f) begin
      // Pixels past the last row of the image are ignored.
      if (row_idx < rows_eff) begin
        if (p < threshold) begin
          row_dark = row_dark + 1'b1;
          if (col_idx < MAX_COLS) begin
            column_dark[col_idx] = column_dark[col_idx] + 1'b1;
          end
        end
        if (col_idx + 1 >= cols_eff) begin
          if (row_idx > 0) begin
            advance_peak_tracker(row_trk, prev_row_dark, row_dark, row_idx - 1,
                                 nt, hit, pos);
            row_trk = nt;
          end
          prev_row_dark = row_dark;
          row_dark      = '0;
          col_idx       = 0;
          row_idx++;
          if (hit) begin
            w.kind     = ppf_pkg::KIND_ROW;
            w.position = pos;
            w.last     = 1'b0;
            expected_peaks.insert(expected_peaks.size(), w);
          end
        end else begin
          col_idx++;
        end
      end
    end else begin
      // A scan step reads and clears one column entry and always reports.
      scan_words++;
      is_last = (scan_idx + 1 >= cols_eff);
      cur     = '0;
      if (scan_idx < MAX_COLS) begin
        cur                   = column_dark[scan_idx];
        column_dark[scan_idx] = '0;
      end
      if (scan_idx > 0) begin
        advance_peak_tracker(col_trk, prev_col_dark, cur, scan_idx - 1, nt, hit, pos);
        col_trk = nt;
      end
      prev_col_dark = cur;
      w.kind        = hit ? ppf_pkg::KIND_COL : ppf_pkg::KIND_NONE;
      w.position    = hit ? pos : '0;
      w.last        = is_last;
      expected_peaks.insert(expected_peaks.size(), w);
      if (is_last) begin
        restart_image();
      end else begin
        scan_idx++;
      end
    end
  endtask

  // Compare one result word with the oldest expected word.
  task automatic check_word;
    peak_word_t w;
    if (expected_peaks.size() == 0) begin
      errors++;
      if (reported < 10) begin
        reported++;
        $display("ERROR: result word with none expected: kind %0d position %0d last %0d",
                 kind, position, last);
      end
    end else begin
      w = expected_peaks.pop_front();
      if (kind !== w.kind || position !== w.position || last !== w.last) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("ERROR: expected kind %0d position %0d last %0d, got %0d %0d %0d",
                   w.kind, w.position, w.last, kind, position, last);
        end
      end else if (w.kind == ppf_pkg::KIND_ROW) begin
        row_peaks++;
      end else if (w.kind == ppf_pkg::KIND_COL) begin
        col_peaks++;
      end
    end
  endtask

  // Results are checked before the word accepted at the same edge is predicted.
  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < MAX_COLS; c++) begin
        column_dark[c] = '0;
      end
      threshold = ppf_pkg::THR_RESET;
      cols_reg  = ppf_pkg::LIM_RESET;
      rows_reg  = ppf_pkg::LIM_RESET;
      restart_image();
      expected_peaks.delete();
    end else begin
      if (done) begin
        check_word();
      end
      if (wr_en) begin
        case (wr_index)
          ppf_pkg::REG_THRESHOLD: begin
            threshold = wr_data[ppf_pkg::THR_W-1:0];
          end
          ppf_pkg::REG_COLS: begin
            cols_reg = wr_data;
          end
          ppf_pkg::REG_ROWS: begin
            rows_reg = wr_data;
          end
          default: begin
          end
        endcase
      end
      if (start && !busy) begin
        predict_word(func, pixel);
      end
    end
    outstanding <= expected_peaks.size();
  end

endmodule

[test/projection_profile_peak_finder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// projection_profile_peak_finder_tb: testbench for the projection peak finder
// Feeds pixel and column scan words in bursts: threshold edges at the reset
// settings, a hand-built image with a row plateau and a column peak, limits
// written outside the legal range with a scan cut short by a lowered column
// limit, then many small random images with early scans, register changes
// inside an image and stray pixels. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module projection_profile_peak_finder_tb;

  localparam int MAX_COLS     = ppf_pkg::MAX_COLS_DEF;
  localparam int MAX_ROWS     = ppf_pkg::MAX_ROWS_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 400;

  logic                       clk      = 1'b0;
  logic                       rst      = 1'b1;
  logic                       start    = 1'b0;
  logic                       func     = 1'b0;
  logic [7:0]                 pixel    = 8'd0;
  logic                       wr_en    = 1'b0;
  logic [ppf_pkg::IDX_W-1:0]  wr_index = ppf_pkg::REG_THRESHOLD;
  logic [ppf_pkg::CFG_W-1:0]  wr_data  = '0;
  logic                       busy;
  logic                       done;
  logic [ppf_pkg::KIND_W-1:0] kind;
  logic [ppf_pkg::POS_W-1:0]  position;
  logic                       last;

  int outstanding;
  int errors;
  int words_in;
  int scan_words;
  int row_peaks;
  int col_peaks;

  int cycles     = 0;
  int burst_left = 0;
  int sent       = 0;
  int settings   = 0;
  int thr_set    = ppf_pkg::THR_RESET;
  int cols_eff   = MAX_COLS;
  int rows_eff   = MAX_ROWS;
  int scan_pos   = 0;

  // Four rows by three columns: row counts 0 2 2 1, column counts 1 3 1,
  // then one pixel past the last row.
  logic [7:0] crafted_pixels [13] = '{8'd255, 8'd128, 8'd255,
                                      8'd0,   8'd127, 8'd200,
                                      8'd128, 8'd0,   8'd127,
                                      8'd255, 8'd0,   8'd128,
                                      8'd0};

  projection_profile_peak_finder #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .func    (func),
    .pixel   (pixel),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .done    (done),
    .kind    (kind),
    .position(position),
    .last    (last)
  );

  ppf_peak_checker #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) peak_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .pixel      (pixel),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .done       (done),
    .kind       (kind),
    .position   (position),
    .last       (last),
    .outstanding(outstanding),
    .errors     (errors),
    .words_in   (words_in),
    .scan_words (scan_words),
    .row_peaks  (row_peaks),
    .col_peaks  (col_peaks)
  );

  always #4 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int size_in_use(input int v, input int maxv);
    return (v < 2) ? 2 : ((v > maxv) ? maxv : v);
  endfunction

  // Small image sizes, now and then below the legal range.
  function automatic logic [ppf_pkg::CFG_W-1:0] random_size;
    return ppf_pkg::CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1)
                                                       : $urandom_range(2, 10));
  endfunction

  function automatic logic [7:0] random_threshold;
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Dark with the given percent chance, with some fully random values.
  function automatic logic [7:0] make_pixel(input int dens);
    if ($urandom_range(0, 9) == 0) begin
      return 8'($urandom);
    end else if (thr_set > 0 && $urandom_range(0, 99) < dens) begin
      return 8'($urandom_range(0, thr_set - 1));
    end
    return 8'($urandom_range(thr_set, 255));
  endfunction

  // Hold off until no result is expected and the block has stayed idle.
  task automatic wait_idle;
    int quiet;
    quiet = 0;
    start <= 1'b0;
    while (quiet < 4) begin
      @(posedge clk);
      quiet = (outstanding == 0 && !busy) ? quiet + 1 : 0;
    end
  endtask

  // Write all three registers while the block is idle.
  task automatic set_config(input logic [7:0] thr, input logic [ppf_pkg::CFG_W-1:0] cols,
                            input logic [ppf_pkg::CFG_W-1:0] rows);
    wait_idle();
    wr_en    <= 1'b1;
    wr_index <= ppf_pkg::REG_THRESHOLD;
    wr_data  <= ppf_pkg::CFG_W'(thr);
    @(posedge clk);
    wr_index <= ppf_pkg::REG_COLS;
    wr_data  <= cols;
    @(posedge clk);
    wr_index <= ppf_pkg::REG_ROWS;
    wr_data  <= rows;
    @(posedge clk);
    wr_en    <= 1'b0;
    thr_set  = thr;
    cols_eff = size_in_use(cols, MAX_COLS);
    rows_eff = size_in_use(rows, MAX_ROWS);
    settings++;
  endtask

  // Send one word, pausing between bursts of random length.
  task automatic send_word(input logic f, input logic [7:0] p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start <= 1'b1;
    func  <= f;
    pixel <= p;
    do @(posedge clk); while (busy);
    sent++;
    if (f) begin
      scan_pos = (scan_pos + 1 >= cols_eff) ? 0 : scan_pos + 1;
    end
  endtask

  // One image and its column scan. Style 0 is well formed but for stray pixels
  // now and then, 1 scans before all rows are in, 2 changes the registers
  // inside the image, 3 sends random pixels and mixes pixels into the scan.
  task automatic run_image(input int style);
    int total;
    int dens;
    int change_at;
    total = rows_eff * cols_eff;
    if (style == 1) begin
      total = $urandom_range(0, total - 1);
    end else if ($urandom_range(0, 3) == 0) begin
      total += $urandom_range(1, 2 * cols_eff);
    end
    change_at = (style == 2) ? $urandom_range(1, total - 1) : -1;
    dens      = 50;
    for (int i = 0; i < total; i++) begin
      if (i == change_at) begin
        set_config(random_threshold(), random_size(), random_size());
      end
      if (i % cols_eff == 0) begin
        dens = $urandom_range(0, 100);
      end
      send_word(1'b0, (style == 3) ? 8'($urandom) : make_pixel(dens));
    end
    do begin
      if (style == 3 && $urandom_range(0, 3) == 0) begin
        send_word(1'b0, 8'($urandom));
      end
      send_word(1'b1, 8'($urandom));
    end while (scan_pos != 0);
  endtask

  initial begin
    int base;
    int pick;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // The column memory clear pass ends when busy drops.
    wait_idle();

    // Threshold edges at the reset settings, then a register change with the
    // row partly done and a scan that ends the image.
    send_word(1'b0, 8'd0);
    send_word(1'b0, 8'd124);
    send_word(1'b0, 8'd125);
    send_word(1'b0, 8'd255);
    set_config(8'd128, 11'd3, 11'd4);
    repeat (3) send_word(1'b1, 8'($urandom));

    // Row plateau peak and a plain column peak.
    foreach (crafted_pixels[i]) begin
      send_word(1'b0, crafted_pixels[i]);
    end
    repeat (3) send_word(1'b1, 8'($urandom));

    // Limits written outside the legal range: a long partial row, then a scan
    // that a lowered column limit ends at once.
    set_config(8'd255, 11'd2047, 11'd0);
    for (int i = 0; i < 40; i++) begin
      send_word(1'b0, make_pixel(50));
    end
    repeat (3) send_word(1'b1, 8'($urandom));
    set_config(8'd128, 11'd1, 11'd2047);
    send_word(1'b1, 8'($urandom));

    // Random small images, mostly well formed.
    base = sent;
    while (sent - base < RANDOM_WORDS) begin
      set_config(random_threshold(), random_size(), random_size());
      pick = $urandom_range(0, 9);
      run_image((pick < 6) ? 0 : pick - 6);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Run covered %0d words, %0d of them column scan steps, over %0d settings.",
             words_in, scan_words, settings);
    $display("Matched %0d row peaks and %0d column peaks, out-of-range limits included.",
             row_peaks, col_peaks);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
